### sv/bps_pkg.sv
// shared constants, types and helper functions for the bilinear pixel sampler
package bps_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int FRAC_BITS   = 8;

    localparam int CHAN_W      = 16;
    localparam int NUM_CHAN    = 4;
    localparam int PIX_W       = CHAN_W * NUM_CHAN;
    localparam int COORD_W     = 17;
    localparam int INDEX_W     = 16;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 2;
    localparam int NUM_TAPS    = 4;

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int MAX_DIM     = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int IDX_W       = $clog2(MAX_DIM);
    localparam int SIZE_W      = $clog2(MAX_DIM + 1);
    localparam int ROW_W       = IDX_W + SIZE_W;
    localparam int POS_W       = COORD_W - FRAC_BITS + 1;
    localparam int CMP_W       = (POS_W > SIZE_W + 1) ? POS_W : SIZE_W + 1;
    localparam int WGT_W       = FRAC_BITS + 1;
    localparam int WP_W        = 2 * WGT_W;
    localparam int WT_W        = 2 * FRAC_BITS + 1;
    localparam int PROD_W      = CHAN_W + WT_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int VAL_W       = SUM_W - 2 * FRAC_BITS;

    localparam logic [WGT_W-1:0]      WEIGHT_ONE    = WGT_W'(1) << FRAC_BITS;
    localparam logic [CFG_DATA_W-1:0] SIZE_RESET    = CFG_DATA_W'(256);
    localparam logic [CHAN_W-1:0]     LIMIT_SHALLOW = CHAN_W'(255);
    localparam logic [CHAN_W-1:0]     LIMIT_DEEP    = CHAN_W'(65535);

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_opcode;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_DEEP_SAMPLES = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic signed [POS_W-1:0] base;
        logic [WGT_W-1:0]        w0;
        logic [WGT_W-1:0]        w1;
    } t_split;

    // truncate toward zero, weights swap for a negative coordinate
    function automatic t_split split_coord(input logic signed [COORD_W-1:0] c);
        t_split                            s;
        logic [COORD_W-1:0]                mag;
        logic [COORD_W-FRAC_BITS-1:0]      ip;
        logic [FRAC_BITS-1:0]              fr;
        logic [WGT_W-1:0]                  rest;
        mag  = c[COORD_W-1] ? COORD_W'(-c) : COORD_W'(c);
        ip   = mag[COORD_W-1:FRAC_BITS];
        fr   = mag[FRAC_BITS-1:0];
        rest = WEIGHT_ONE - {1'b0, fr};
        if (c[COORD_W-1]) begin
            s.base = -$signed({1'b0, ip});
            s.w0   = {1'b0, fr};
            s.w1   = rest;
        end else begin
            s.base = $signed({1'b0, ip});
            s.w0   = rest;
            s.w1   = {1'b0, fr};
        end
        return s;
    endfunction

    // zero acts as one, oversize acts as the maximum
    function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_DATA_W-1:0] r,
                                                   input int maxv);
        if (r == '0) begin
            return SIZE_W'(1);
        end else if (int'(r) > maxv) begin
            return SIZE_W'(maxv);
        end else begin
            return SIZE_W'(r);
        end
    endfunction

    // clamp a neighbour position to 0 .. size-1
    function automatic logic [IDX_W-1:0] clamp_pos(input logic signed [POS_W-1:0] p,
                                                   input logic [SIZE_W-1:0] size);
        logic signed [CMP_W-1:0] ps;
        logic signed [CMP_W-1:0] sz;
        ps = CMP_W'(p);
        sz = $signed(CMP_W'({1'b0, size}));
        if (ps < 0) begin
            return '0;
        end else if (ps >= sz) begin
            return IDX_W'(size - 1'b1);
        end else begin
            return IDX_W'(ps);
        end
    endfunction

endpackage

### sv/bilinear_pixel_sampler.sv
// bilinear rgba sampler over an on-chip image store, pipelined at one beat per cycle
//
// Load beats write one 64-bit pixel into the image store; sample beats return one
// interpolated pixel with edge clamping. The block takes one beat every cycle unless
// it holds. A sample passes six registers (input register, coordinate split, address
// and weight products, store read, channel products, sum and clamp). The store is
// held twice, each copy with one write and two read ports, so the four neighbours of a
// sample are read in the same cycle; a load is seen by every later sample. The whole
// pipeline holds while a result waits on i_out_stall. Store entries hold no value until
// loaded; configuration is to be written only while the block is idle, a rule for the
// user that the block itself does not enforce.
module bilinear_pixel_sampler (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_opcode,
    input  logic [bps_pkg::INDEX_W-1:0]           i_load_index,
    input  logic [bps_pkg::CHAN_W-1:0]            i_load_blue,
    input  logic [bps_pkg::CHAN_W-1:0]            i_load_green,
    input  logic [bps_pkg::CHAN_W-1:0]            i_load_red,
    input  logic [bps_pkg::CHAN_W-1:0]            i_load_alpha,
    input  logic signed [bps_pkg::COORD_W-1:0]    i_coord_x,
    input  logic signed [bps_pkg::COORD_W-1:0]    i_coord_y,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [bps_pkg::CHAN_W-1:0]            o_out_blue,
    output logic [bps_pkg::CHAN_W-1:0]            o_out_green,
    output logic [bps_pkg::CHAN_W-1:0]            o_out_red,
    output logic [bps_pkg::CHAN_W-1:0]            o_out_alpha,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [bps_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    // configuration
    logic [bps_pkg::CFG_DATA_W-1:0] r_width;
    logic [bps_pkg::CFG_DATA_W-1:0] r_height;
    logic                           r_deep;

    // pipeline control
    logic w_adv;
    logic r1_valid, r2_valid, r3_valid, r4_valid, r5_valid, r_out_valid;
    bps_pkg::t_opcode r1_op, r2_op, r3_op;

    // stage 1: captured beat
    logic [bps_pkg::INDEX_W-1:0]        r1_load_index;
    logic [bps_pkg::PIX_W-1:0]          r1_load_pix;
    logic signed [bps_pkg::COORD_W-1:0] r1_coord_x;
    logic signed [bps_pkg::COORD_W-1:0] r1_coord_y;

    // stage 2: clamped positions and weights
    logic [bps_pkg::INDEX_W-1:0] r2_load_index;
    logic [bps_pkg::PIX_W-1:0]   r2_load_pix;
    logic [bps_pkg::IDX_W-1:0]   r2_cx [2];
    logic [bps_pkg::IDX_W-1:0]   r2_cy [2];
    logic [bps_pkg::WGT_W-1:0]   r2_wx [2];
    logic [bps_pkg::WGT_W-1:0]   r2_wy [2];

    // stage 3: store addresses and weight products
    logic [bps_pkg::INDEX_W-1:0] r3_load_index;
    logic [bps_pkg::PIX_W-1:0]   r3_load_pix;
    logic [bps_pkg::ADDR_W-1:0]  r3_addr [bps_pkg::NUM_TAPS];
    logic [bps_pkg::WT_W-1:0]    r3_wt   [bps_pkg::NUM_TAPS];

    // stage 4: neighbour pixels
    logic [bps_pkg::PIX_W-1:0] r4_pix [bps_pkg::NUM_TAPS];
    logic [bps_pkg::WT_W-1:0]  r4_wt  [bps_pkg::NUM_TAPS];

    // stage 5: weighted channels
    logic [bps_pkg::PROD_W-1:0] r5_prod [bps_pkg::NUM_TAPS][bps_pkg::NUM_CHAN];

    // output register
    logic [bps_pkg::CHAN_W-1:0] r_out_chan [bps_pkg::NUM_CHAN];

    // image store, two copies for four reads a cycle
    logic [bps_pkg::PIX_W-1:0] r_mem_a [bps_pkg::STORE_DEPTH];
    logic [bps_pkg::PIX_W-1:0] r_mem_b [bps_pkg::STORE_DEPTH];

    // combinational
    bps_pkg::t_split                  w_sx, w_sy;
    logic [bps_pkg::SIZE_W-1:0]       w_eff_w, w_eff_h;
    logic signed [bps_pkg::POS_W-1:0] w_bx1, w_by1;
    logic [bps_pkg::IDX_W-1:0]        n_cx [2];
    logic [bps_pkg::IDX_W-1:0]        n_cy [2];
    logic [bps_pkg::ROW_W-1:0]        w_row  [bps_pkg::NUM_TAPS];
    logic [bps_pkg::WP_W-1:0]         w_wp   [bps_pkg::NUM_TAPS];
    logic [bps_pkg::ADDR_W-1:0]       n_addr [bps_pkg::NUM_TAPS];
    logic [bps_pkg::WT_W-1:0]         n_wt   [bps_pkg::NUM_TAPS];
    logic [bps_pkg::PROD_W-1:0]       n_prod [bps_pkg::NUM_TAPS][bps_pkg::NUM_CHAN];
    logic [bps_pkg::SUM_W-1:0]        w_sum  [bps_pkg::NUM_CHAN];
    logic [bps_pkg::VAL_W-1:0]        w_val  [bps_pkg::NUM_CHAN];
    logic [bps_pkg::CHAN_W-1:0]       n_out  [bps_pkg::NUM_CHAN];
    logic [bps_pkg::CHAN_W-1:0]       w_limit;
    logic                             w_wr;

    assign w_adv       = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !w_adv;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid = r_out_valid;
    assign o_out_blue  = r_out_chan[0];
    assign o_out_green = r_out_chan[1];
    assign o_out_red   = r_out_chan[2];
    assign o_out_alpha = r_out_chan[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= bps_pkg::SIZE_RESET;
            r_height <= bps_pkg::SIZE_RESET;
            r_deep   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (bps_pkg::t_cfg_index'(i_cfg_index))
                bps_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                bps_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                bps_pkg::CFG_DEEP_SAMPLES: r_deep   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // valid bits; loads leave the pipe after the store write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid    <= i_in_valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r4_valid    <= r3_valid && (r3_op == bps_pkg::OP_SAMPLE);
            r5_valid    <= r4_valid;
            r_out_valid <= r5_valid;
        end
    end

    // stage 1 -> 2: split coordinates and clamp neighbours
    assign w_eff_w = bps_pkg::eff_size(r_width, bps_pkg::MAX_WIDTH);
    assign w_eff_h = bps_pkg::eff_size(r_height, bps_pkg::MAX_HEIGHT);
    assign w_sx    = bps_pkg::split_coord(r1_coord_x);
    assign w_sy    = bps_pkg::split_coord(r1_coord_y);
    assign w_bx1   = w_sx.base + bps_pkg::POS_W'(1);
    assign w_by1   = w_sy.base + bps_pkg::POS_W'(1);

    always_comb begin
        n_cx[0] = bps_pkg::clamp_pos(w_sx.base, w_eff_w);
        n_cx[1] = bps_pkg::clamp_pos(w_bx1, w_eff_w);
        n_cy[0] = bps_pkg::clamp_pos(w_sy.base, w_eff_h);
        n_cy[1] = bps_pkg::clamp_pos(w_by1, w_eff_h);
    end

    // stage 2 -> 3: tap n takes column n[1] and row n[0]
    always_comb begin
        for (int n = 0; n < bps_pkg::NUM_TAPS; n++) begin
            w_row[n]  = bps_pkg::ROW_W'(r2_cy[n % 2]) * bps_pkg::ROW_W'(w_eff_w);
            n_addr[n] = bps_pkg::ADDR_W'(w_row[n] + bps_pkg::ROW_W'(r2_cx[n / 2]));
            w_wp[n]   = bps_pkg::WP_W'(r2_wx[n / 2]) * bps_pkg::WP_W'(r2_wy[n % 2]);
            n_wt[n]   = w_wp[n][bps_pkg::WT_W-1:0];
        end
    end

    // stage 4 -> 5: one product per tap and channel
    always_comb begin
        for (int n = 0; n < bps_pkg::NUM_TAPS; n++) begin
            for (int c = 0; c < bps_pkg::NUM_CHAN; c++) begin
                n_prod[n][c] = bps_pkg::PROD_W'(r4_pix[n][c*bps_pkg::CHAN_W +: bps_pkg::CHAN_W])
                             * bps_pkg::PROD_W'(r4_wt[n]);
            end
        end
    end

    // stage 5 -> out: sum, truncate, clamp
    assign w_limit = r_deep ? bps_pkg::LIMIT_DEEP : bps_pkg::LIMIT_SHALLOW;

    always_comb begin
        for (int c = 0; c < bps_pkg::NUM_CHAN; c++) begin
            w_sum[c] = bps_pkg::SUM_W'(r5_prod[0][c]) + bps_pkg::SUM_W'(r5_prod[1][c])
                     + bps_pkg::SUM_W'(r5_prod[2][c]) + bps_pkg::SUM_W'(r5_prod[3][c]);
            w_val[c] = w_sum[c][bps_pkg::SUM_W-1:2*bps_pkg::FRAC_BITS];
            n_out[c] = (w_val[c] > bps_pkg::VAL_W'(w_limit)) ? w_limit
                                                            : w_val[c][bps_pkg::CHAN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_op         <= bps_pkg::t_opcode'(i_opcode);
            r1_load_index <= i_load_index;
            r1_load_pix   <= {i_load_alpha, i_load_red, i_load_green, i_load_blue};
            r1_coord_x    <= i_coord_x;
            r1_coord_y    <= i_coord_y;

            r2_op         <= r1_op;
            r2_load_index <= r1_load_index;
            r2_load_pix   <= r1_load_pix;
            r2_cx         <= n_cx;
            r2_cy         <= n_cy;
            r2_wx[0]      <= w_sx.w0;
            r2_wx[1]      <= w_sx.w1;
            r2_wy[0]      <= w_sy.w0;
            r2_wy[1]      <= w_sy.w1;

            r3_op         <= r2_op;
            r3_load_index <= r2_load_index;
            r3_load_pix   <= r2_load_pix;
            r3_addr       <= n_addr;
            r3_wt         <= n_wt;

            r4_wt         <= r3_wt;
            r5_prod       <= n_prod;
            r_out_chan    <= n_out;
        end
    end

    // store write and reads sit in the same stage, so a load is seen by the next sample
    assign w_wr = w_adv && r3_valid && (r3_op == bps_pkg::OP_LOAD)
               && (int'(r3_load_index) < bps_pkg::STORE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem_a[bps_pkg::ADDR_W'(r3_load_index)] <= r3_load_pix;
            r_mem_b[bps_pkg::ADDR_W'(r3_load_index)] <= r3_load_pix;
        end
        if (w_adv) begin
            r4_pix[0] <= r_mem_a[r3_addr[0]];
            r4_pix[1] <= r_mem_a[r3_addr[1]];
            r4_pix[2] <= r_mem_b[r3_addr[2]];
            r4_pix[3] <= r_mem_b[r3_addr[3]];
        end
    end

endmodule

### sv/bps_checker.sv
// port-level checker for the bilinear pixel sampler, bound to the top level
module bps_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               o_in_stall,
    input  logic                               i_opcode,
    input  logic                               o_out_valid,
    input  logic                               i_out_stall,
    input  logic [bps_pkg::CHAN_W-1:0]         o_out_blue,
    input  logic [bps_pkg::CHAN_W-1:0]         o_out_green,
    input  logic [bps_pkg::CHAN_W-1:0]         o_out_red,
    input  logic [bps_pkg::CHAN_W-1:0]         o_out_alpha,
    input  logic                               i_cfg_valid,
    input  logic                               o_cfg_ready,
    input  logic [bps_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic       r_deep;
    logic [3:0] r_pending;
    logic       w_in_sample;
    logic       w_out_beat;

    assign w_in_sample = i_in_valid && !o_in_stall
                      && (bps_pkg::t_opcode'(i_opcode) == bps_pkg::OP_SAMPLE);
    assign w_out_beat  = o_out_valid && !i_out_stall;

    // mirror of the depth mode and count of samples taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deep    <= 1'b0;
            r_pending <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready
                && (i_cfg_index == bps_pkg::CFG_DEEP_SAMPLES)) begin
                r_deep <= i_cfg_data[0];
            end
            r_pending <= r_pending + {3'b000, w_in_sample} - {3'b000, w_out_beat};
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_blue)
            && $stable(o_out_green) && $stable(o_out_red) && $stable(o_out_alpha))
        else $error("result beat changed while stalled");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_beat |-> r_pending != 4'd0)
        else $error("result beat without a pending sample");

    a_shallow_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !$past(o_out_valid && i_out_stall) && !$past(r_deep)
            |-> (o_out_blue <= bps_pkg::LIMIT_SHALLOW)
             && (o_out_green <= bps_pkg::LIMIT_SHALLOW)
             && (o_out_red <= bps_pkg::LIMIT_SHALLOW)
             && (o_out_alpha <= bps_pkg::LIMIT_SHALLOW))
        else $error("8-bit mode result above 255");

endmodule

bind bilinear_pixel_sampler bps_checker u_bps_checker (.*);

### dv/tb_bilinear_pixel_sampler.sv
// self-checking testbench for the bilinear pixel sampler: pixel loads, samples, register settings
`timescale 1ns / 1ps

module tb_bilinear_pixel_sampler;

    localparam int PIPE_SLACK   = 12;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 360;
    localparam int PHASES       = 6;

    typedef struct packed {
        logic [bps_pkg::CHAN_W-1:0] alpha;
        logic [bps_pkg::CHAN_W-1:0] red;
        logic [bps_pkg::CHAN_W-1:0] green;
        logic [bps_pkg::CHAN_W-1:0] blue;
    } t_pixel;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_stall;
    logic                               i_opcode = 1'b0;
    logic [bps_pkg::INDEX_W-1:0]        i_load_index = '0;
    logic [bps_pkg::CHAN_W-1:0]         i_load_blue = '0;
    logic [bps_pkg::CHAN_W-1:0]         i_load_green = '0;
    logic [bps_pkg::CHAN_W-1:0]         i_load_red = '0;
    logic [bps_pkg::CHAN_W-1:0]         i_load_alpha = '0;
    logic signed [bps_pkg::COORD_W-1:0] i_coord_x = '0;
    logic signed [bps_pkg::COORD_W-1:0] i_coord_y = '0;
    logic                               o_out_valid;
    logic                               i_out_stall = 1'b0;
    logic [bps_pkg::CHAN_W-1:0]         o_out_blue;
    logic [bps_pkg::CHAN_W-1:0]         o_out_green;
    logic [bps_pkg::CHAN_W-1:0]         o_out_red;
    logic [bps_pkg::CHAN_W-1:0]         o_out_alpha;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    bps_pkg::t_cfg_index                i_cfg_index = bps_pkg::CFG_IMAGE_WIDTH;
    logic [bps_pkg::CFG_DATA_W-1:0]     i_cfg_data = '0;

    // local copy of the block state
    logic [bps_pkg::PIX_W-1:0]      image_copy [bps_pkg::STORE_DEPTH];
    bit                             image_loaded [bps_pkg::STORE_DEPTH];
    logic [bps_pkg::CFG_DATA_W-1:0] cfg_width = bps_pkg::SIZE_RESET;
    logic [bps_pkg::CFG_DATA_W-1:0] cfg_height = bps_pkg::SIZE_RESET;
    logic                           cfg_deep = 1'b0;

    t_pixel pending_pixels [$];
    int     fault_count = 0;
    int     beat_count = 0;
    bit     jitter_on = 1'b1;

    bilinear_pixel_sampler dut (.*);

    always #1 i_clk = ~i_clk;

    initial begin
        #2000000;
        $display("bilinear_pixel_sampler verification failed");
        $finish;
    end

    function automatic int active_size(input logic [bps_pkg::CFG_DATA_W-1:0] r,
                                       input int maxv);
        int s;
        s = r;
        if (s < 1) s = 1;
        if (s > maxv) s = maxv;
        return s;
    endfunction

    function automatic int clamp_tap(input int p, input int size);
        if (p < 0) return 0;
        if (p >= size) return size - 1;
        return p;
    endfunction

    function automatic int tap_addr(input int px, input int py);
        int w;
        int h;
        w = active_size(cfg_width, bps_pkg::MAX_WIDTH);
        h = active_size(cfg_height, bps_pkg::MAX_HEIGHT);
        return clamp_tap(py, h) * w + clamp_tap(px, w);
    endfunction

    // truncate toward zero; a negative coordinate swaps its weights
    function automatic void coord_weights(input logic signed [bps_pkg::COORD_W-1:0] c,
                                          output int base, output int w0, output int w1);
        int v;
        int mag;
        int ip;
        int fr;
        v   = c;
        mag = (v < 0) ? -v : v;
        ip  = mag >> bps_pkg::FRAC_BITS;
        fr  = mag & ((1 << bps_pkg::FRAC_BITS) - 1);
        if (v < 0) begin
            base = -ip;
            w0   = fr;
            w1   = (1 << bps_pkg::FRAC_BITS) - fr;
        end else begin
            base = ip;
            w0   = (1 << bps_pkg::FRAC_BITS) - fr;
            w1   = fr;
        end
    endfunction

    function automatic t_pixel blend_sample(input logic signed [bps_pkg::COORD_W-1:0] x,
                                            input logic signed [bps_pkg::COORD_W-1:0] y);
        int                        bx;
        int                        by;
        int                        wx [2];
        int                        wy [2];
        longint unsigned           acc [bps_pkg::NUM_CHAN];
        longint unsigned           term;
        longint unsigned           limit;
        logic [bps_pkg::PIX_W-1:0] px;
        logic [bps_pkg::PIX_W-1:0] res;
        coord_weights(x, bx, wx[0], wx[1]);
        coord_weights(y, by, wy[0], wy[1]);
        for (int c = 0; c < bps_pkg::NUM_CHAN; c++) acc[c] = 0;
        for (int i = 0; i < 2; i++) begin
            for (int k = 0; k < 2; k++) begin
                px = image_copy[tap_addr(bx + i, by + k)];
                for (int c = 0; c < bps_pkg::NUM_CHAN; c++) begin
                    term   = px[bps_pkg::CHAN_W*c +: bps_pkg::CHAN_W];
                    acc[c] += term * longint'(wx[i] * wy[k]);
                end
            end
        end
        limit = cfg_deep ? bps_pkg::LIMIT_DEEP : bps_pkg::LIMIT_SHALLOW;
        for (int c = 0; c < bps_pkg::NUM_CHAN; c++) begin
            term = acc[c] >> (2 * bps_pkg::FRAC_BITS);
            if (term > limit) term = limit;
            res[bps_pkg::CHAN_W*c +: bps_pkg::CHAN_W] = term[bps_pkg::CHAN_W-1:0];
        end
        return t_pixel'(res);
    endfunction

    function automatic logic [bps_pkg::CHAN_W-1:0] rand_channel();
        case ($urandom_range(0, 9))
            0:       return '1;
            1:       return '0;
            2, 3, 4: return bps_pkg::CHAN_W'($urandom_range(0, 255));
            default: return bps_pkg::CHAN_W'($urandom);
        endcase
    endfunction

    function automatic t_pixel rand_pixel();
        t_pixel p;
        p.blue  = rand_channel();
        p.green = rand_channel();
        p.red   = rand_channel();
        p.alpha = rand_channel();
        return p;
    endfunction

    // mostly near the image, some anywhere, some on whole pixels of either sign
    function automatic logic signed [bps_pkg::COORD_W-1:0] pick_coord(input int size);
        int v;
        case ($urandom_range(0, 9))
            0, 1: v = $urandom;
            2, 3: begin
                v = $urandom_range(0, size + 1) * (1 << bps_pkg::FRAC_BITS);
                if ($urandom_range(0, 1)) v = -v;
            end
            default: v = int'($urandom_range(0, (size + 2) << bps_pkg::FRAC_BITS))
                         - (2 << bps_pkg::FRAC_BITS);
        endcase
        return bps_pkg::COORD_W'(v);
    endfunction

    function automatic logic [bps_pkg::CFG_DATA_W-1:0] pick_size();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return bps_pkg::CFG_DATA_W'(511);
            2:       return bps_pkg::CFG_DATA_W'(256);
            3:       return bps_pkg::CFG_DATA_W'($urandom_range(1, 256));
            default: return bps_pkg::CFG_DATA_W'($urandom_range(1, 16));
        endcase
    endfunction

    function automatic void check_channel(input string field,
                                          input logic [bps_pkg::CHAN_W-1:0] want,
                                          input logic [bps_pkg::CHAN_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            fault_count++;
        end
    endfunction

    // result side: compare each beat with the oldest expectation, stall at random
    always @(posedge i_clk) begin : result_check
        t_pixel want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_pixels.size() == 0) begin
                $error("result beat with no sample waiting");
                fault_count++;
            end else begin
                want = pending_pixels.pop_front();
                check_channel("out_blue", want.blue, o_out_blue);
                check_channel("out_green", want.green, o_out_green);
                check_channel("out_red", want.red, o_out_red);
                check_channel("out_alpha", want.alpha, o_out_alpha);
            end
        end
        i_out_stall <= i_rst_n && jitter_on && ($urandom_range(0, 99) < 19);
    end

    task automatic send_beat(input bps_pkg::t_opcode op,
                             input logic [bps_pkg::INDEX_W-1:0] idx, input t_pixel data,
                             input logic signed [bps_pkg::COORD_W-1:0] x,
                             input logic signed [bps_pkg::COORD_W-1:0] y);
        while (jitter_on && $urandom_range(0, 99) < 19) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_load_index <= idx;
        i_load_blue  <= data.blue;
        i_load_green <= data.green;
        i_load_red   <= data.red;
        i_load_alpha <= data.alpha;
        i_coord_x    <= x;
        i_coord_y    <= y;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        beat_count++;
        if (op == bps_pkg::OP_LOAD) begin
            image_copy[idx]   = data;
            image_loaded[idx] = 1'b1;
        end else begin
            pending_pixels.push_back(blend_sample(x, y));
        end
    endtask

    task automatic load_pixel(input logic [bps_pkg::INDEX_W-1:0] idx, input t_pixel data);
        send_beat(bps_pkg::OP_LOAD, idx, data, bps_pkg::COORD_W'($urandom),
                  bps_pkg::COORD_W'($urandom));
    endtask

    // fill any neighbour that was never loaded before sampling
    task automatic sample_at(input logic signed [bps_pkg::COORD_W-1:0] x,
                             input logic signed [bps_pkg::COORD_W-1:0] y);
        int bx;
        int by;
        int w0;
        int w1;
        int a;
        coord_weights(x, bx, w0, w1);
        coord_weights(y, by, w0, w1);
        for (int i = 0; i < 2; i++) begin
            for (int k = 0; k < 2; k++) begin
                a = tap_addr(bx + i, by + k);
                if (!image_loaded[a]) load_pixel(bps_pkg::INDEX_W'(a), rand_pixel());
            end
        end
        send_beat(bps_pkg::OP_SAMPLE, bps_pkg::INDEX_W'($urandom), rand_pixel(), x, y);
    endtask

    task automatic wait_results();
        int spin;
        i_in_valid <= 1'b0;
        spin = 0;
        do begin
            @(posedge i_clk);
            spin++;
        end while (pending_pixels.size() != 0 && spin < DRAIN_LIMIT);
    endtask

    // loads give no result beat, so leave room for one still in flight
    task automatic settle_pipeline();
        wait_results();
        repeat (PIPE_SLACK) @(posedge i_clk);
    endtask

    task automatic write_reg(input bps_pkg::t_cfg_index idx,
                             input logic [bps_pkg::CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        case (idx)
            bps_pkg::CFG_IMAGE_WIDTH:  cfg_width = value;
            bps_pkg::CFG_IMAGE_HEIGHT: cfg_height = value;
            bps_pkg::CFG_DEEP_SAMPLES: cfg_deep = value[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [bps_pkg::CFG_DATA_W-1:0] w,
                                input logic [bps_pkg::CFG_DATA_W-1:0] h, input logic deep);
        settle_pipeline();
        write_reg(bps_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(bps_pkg::CFG_IMAGE_HEIGHT, h);
        write_reg(bps_pkg::CFG_DEEP_SAMPLES, bps_pkg::CFG_DATA_W'(deep));
    endtask

    // reset settings: corner pixels, coordinate extremes, full-scale values in 8-bit mode
    task automatic test_field_extremes();
        load_pixel('0, t_pixel'('1));
        load_pixel('1, t_pixel'('0));
        sample_at(bps_pkg::COORD_W'(0), bps_pkg::COORD_W'(0));
        sample_at(bps_pkg::COORD_W'(65535), bps_pkg::COORD_W'(65535));
        sample_at(bps_pkg::COORD_W'(-65536), bps_pkg::COORD_W'(-65536));
        sample_at(bps_pkg::COORD_W'(128), bps_pkg::COORD_W'(128));
    endtask

    // zero and oversize register values
    task automatic test_size_registers();
        apply_config(bps_pkg::CFG_DATA_W'(0), bps_pkg::CFG_DATA_W'(511), 1'b1);
        sample_at(bps_pkg::COORD_W'(300), bps_pkg::COORD_W'(-100));
        sample_at(bps_pkg::COORD_W'(640), bps_pkg::COORD_W'(65000));
        apply_config(bps_pkg::CFG_DATA_W'(511), bps_pkg::CFG_DATA_W'(0), 1'b0);
        sample_at(bps_pkg::COORD_W'(65535), bps_pkg::COORD_W'(-300));
        apply_config(bps_pkg::CFG_DATA_W'(1), bps_pkg::CFG_DATA_W'(1), 1'b1);
        sample_at(bps_pkg::COORD_W'(-65536), bps_pkg::COORD_W'(65535));
    endtask

    // negative coordinates swap weights; whole negative ones pick base + 1
    task automatic test_negative_weights();
        apply_config(bps_pkg::CFG_DATA_W'(4), bps_pkg::CFG_DATA_W'(3), 1'b0);
        sample_at(bps_pkg::COORD_W'(-256), bps_pkg::COORD_W'(-256));
        sample_at(bps_pkg::COORD_W'(-128), bps_pkg::COORD_W'(384));
        sample_at(bps_pkg::COORD_W'(-1), bps_pkg::COORD_W'(-511));
        sample_at(bps_pkg::COORD_W'(-768), bps_pkg::COORD_W'(0));
    endtask

    // each phase runs until its share of beats, neighbour loads included, has gone out
    task automatic test_random_traffic();
        int                          w;
        int                          h;
        int                          per_phase;
        int                          phase_start;
        bit                          drained;
        logic [bps_pkg::INDEX_W-1:0] idx;
        per_phase = RANDOM_ITEMS / PHASES;
        for (int p = 0; p < PHASES; p++) begin
            apply_config(pick_size(), pick_size(), 1'($urandom_range(0, 1)));
            w = active_size(cfg_width, bps_pkg::MAX_WIDTH);
            h = active_size(cfg_height, bps_pkg::MAX_HEIGHT);
            jitter_on = (p != 3);
            phase_start = beat_count;
            drained = 1'b0;
            while (beat_count - phase_start < per_phase) begin
                if (p == 1 && !drained && beat_count - phase_start >= per_phase / 2) begin
                    wait_results();
                    drained = 1'b1;
                end
                if ($urandom_range(0, 9) < 3) begin
                    if ($urandom_range(0, 1)) idx = bps_pkg::INDEX_W'($urandom);
                    else idx = bps_pkg::INDEX_W'($urandom_range(0, w * h - 1));
                    load_pixel(idx, rand_pixel());
                end else begin
                    sample_at(pick_coord(w), pick_coord(h));
                end
            end
        end
        jitter_on = 1'b1;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_field_extremes();
        test_size_registers();
        test_negative_weights();
        test_random_traffic();
        settle_pipeline();
        if (pending_pixels.size() != 0) begin
            $error("%0d samples never returned a result", pending_pixels.size());
            fault_count++;
        end
        if (fault_count == 0) begin
            $display("bilinear_pixel_sampler verification clean");
        end else begin
            $display("bilinear_pixel_sampler verification failed");
        end
        $finish;
    end

endmodule
